>>> rtl/cocl_pkg.sv
// Shared types and constants for the column occlusion run clipper.
package cocl_pkg;

    // Column positions include the one-past-the-end value, so they are one bit wider.
    localparam int POS_W = 8;
    localparam int RUN_W = 7;

    localparam logic KIND_CLIP  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic             want_covered;
    } t_find_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] idx;
    } t_find_rsp;

endpackage

>>> rtl/cocl_in_if.sv
// Handshake channel that carries clip and clear items into the block.
interface cocl_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [cocl_pkg::POS_W-1:0] first_col;
    logic [cocl_pkg::POS_W-1:0] end_col;
    logic                       solid;

    modport source (output valid, output kind, output first_col, output end_col,
                    output solid, input ready);
    modport sink   (input valid, input kind, input first_col, input end_col,
                    input solid, output ready);
endinterface

>>> rtl/cocl_out_if.sv
// Handshake channel that carries visible runs out of the block.
interface cocl_out_if;
    logic                       valid;
    logic                       ready;
    logic [cocl_pkg::RUN_W-1:0] run_first;
    logic [cocl_pkg::RUN_W-1:0] run_last;
    logic                       final_run;

    modport source (output valid, output run_first, output run_last, output final_run,
                    input ready);
    modport sink   (input valid, input run_first, input run_last, input final_run,
                    output ready);
endinterface

>>> rtl/column_occlusion_run_clipper.sv
// A clear item, or a clip item whose range is empty, is handled in the idle state alone; a clip
// item with visible runs needs one find-first for the start of each run and one for its end,
// all on the single shared find-first unit, plus one closing search that finds no start. A stall
// by the result receiver while a run waits holds the scan. The input is not ready during a scan,
// so a new item is taken only once the scan of the last one is through.
// Reset: synchronous, active low; all coverage flip-flops clear at once, with no clearing pass.
module column_occlusion_run_clipper #(
    parameter int COLUMNS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cocl_in_if.sink    i_item,
    cocl_out_if.source o_run
);
    import cocl_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_FIND_START, S_FIND_END, S_FLUSH} t_state;

    t_state             r_state;
    logic [COLUMNS-1:0] r_cov;
    logic [POS_W-1:0]   r_col;
    logic [POS_W-1:0]   r_end;
    logic               r_solid;
    logic               r_pend_valid;
    logic [RUN_W-1:0]   r_pend_first;
    logic [RUN_W-1:0]   r_pend_last;
    logic               r_out_valid;
    logic [RUN_W-1:0]   r_out_first;
    logic [RUN_W-1:0]   r_out_last;
    logic               r_out_final;

    t_find_req          find_req;
    t_find_rsp          find_rsp;
    logic [POS_W-1:0]   end_sat;
    logic [POS_W-1:0]   run_end;
    logic [POS_W-1:0]   run_end_m1;
    logic [COLUMNS-1:0] run_mask;
    logic               out_free;
    logic               out_load;

    assign find_req.lo           = r_col;
    assign find_req.hi           = r_end;
    assign find_req.want_covered = (r_state == S_FIND_END);

    cocl_find #(.COLUMNS(COLUMNS)) u_find (
        .i_bits (r_cov),
        .i_req  (find_req),
        .o_rsp  (find_rsp)
    );

    assign end_sat    = (i_item.end_col > POS_W'(COLUMNS)) ? POS_W'(COLUMNS) : i_item.end_col;
    // A run stops at the first covered column, or at the range end when none is found.
    assign run_end    = find_rsp.found ? find_rsp.idx : r_end;
    assign run_end_m1 = run_end - POS_W'(1);
    assign out_free   = !r_out_valid || o_run.ready;
    // The held run moves to the output register this cycle.
    assign out_load   = out_free && (((r_state == S_FIND_START) && r_pend_valid) ||
                                     (r_state == S_FLUSH));

    always_comb begin
        for (int i = 0; i < COLUMNS; i++) begin
            run_mask[i] = (POS_W'(i) >= r_col) && (POS_W'(i) < run_end);
        end
    end

    assign i_item.ready    = (r_state == S_IDLE);
    assign o_run.valid     = r_out_valid;
    assign o_run.run_first = r_out_first;
    assign o_run.run_last  = r_out_last;
    assign o_run.final_run = r_out_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cov        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_run.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        if (i_item.kind == KIND_CLEAR) begin
                            r_cov <= '0;
                        end else if (i_item.first_col < end_sat) begin
                            r_col   <= i_item.first_col;
                            r_end   <= end_sat;
                            r_solid <= i_item.solid;
                            r_state <= S_FIND_START;
                        end
                    end
                end
                S_FIND_START: begin
                    if (!find_rsp.found) begin
                        if (!r_pend_valid) begin
                            r_state <= S_IDLE;
                        end else if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_first  <= r_pend_first;
                            r_out_last   <= r_pend_last;
                            r_out_final  <= 1'b1;
                            r_pend_valid <= 1'b0;
                            r_state      <= S_IDLE;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end else if (!r_pend_valid || out_free) begin
                        // Another run follows, so the held run is not the last one.
                        if (r_pend_valid) begin
                            r_out_valid <= 1'b1;
                            r_out_first <= r_pend_first;
                            r_out_last  <= r_pend_last;
                            r_out_final <= 1'b0;
                        end
                        r_pend_valid <= 1'b0;
                        r_col        <= find_rsp.idx;
                        r_state      <= S_FIND_END;
                    end
                end
                S_FIND_END: begin
                    r_pend_valid <= 1'b1;
                    r_pend_first <= r_col[RUN_W-1:0];
                    r_pend_last  <= run_end_m1[RUN_W-1:0];
                    if (r_solid) begin
                        r_cov <= r_cov | run_mask;
                    end
                    r_col   <= run_end;
                    r_state <= S_FIND_START;
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_first  <= r_pend_first;
                        r_out_last   <= r_pend_last;
                        r_out_final  <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/cocl_find.sv
// Shared find-first unit: lowest column in a range whose coverage bit matches a polarity.
module cocl_find #(
    parameter int COLUMNS = 128
) (
    input  logic [COLUMNS-1:0]  i_bits,
    input  cocl_pkg::t_find_req i_req,
    output cocl_pkg::t_find_rsp o_rsp
);
    import cocl_pkg::*;

    logic [COLUMNS-1:0] cand;

    always_comb begin
        for (int i = 0; i < COLUMNS; i++) begin
            cand[i] = (i_bits[i] == i_req.want_covered) &&
                      (POS_W'(i) >= i_req.lo) && (POS_W'(i) < i_req.hi);
        end
    end

    // Scanning downward leaves the lowest matching column in the result.
    always_comb begin
        o_rsp.found = 1'b0;
        o_rsp.idx   = '0;
        for (int i = COLUMNS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                o_rsp.found = 1'b1;
                o_rsp.idx   = POS_W'(i);
            end
        end
    end

endmodule
